### sv/mbps_pkg.sv
`timescale 1ns / 1ps
package mbps_pkg;

  // input item modes
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_REGION = 1'b1;

  // result item kinds
  localparam logic KIND_MATCH   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // configuration register indexes
  localparam int          CFG_IW             = 2;
  localparam logic [1:0]  CFG_PATTERN_LENGTH = 2'd0;
  localparam logic [1:0]  CFG_REGION_BASE    = 2'd1;
  localparam logic [1:0]  CFG_MAX_REPORTED   = 2'd2;

  // register reset values and limits
  localparam logic [7:0]  PATTERN_LENGTH_RST = 8'd1;
  localparam logic [6:0]  MAX_REPORTED_RST   = 7'd50;
  localparam logic [6:0]  REPORT_CAP         = 7'd64;

  // result queue sizing: two results may enter per cycle
  localparam int          OUTQ_DEPTH = 4;
  localparam int          OUTQ_AW    = 2;
  localparam int          OUTQ_CW    = 3;
  localparam logic [2:0]  OUTQ_ROOM  = 3'd2;

  typedef struct packed {
    logic        kind;
    logic [63:0] match_address;
    logic [6:0]  match_total;
    logic        is_last;
  } result_t;

endpackage

### sv/mbps_match.sv
`timescale 1ns / 1ps
module mbps_match import mbps_pkg::*; #(
  parameter int MAX_PATTERN = 128,
  localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load_en,
  input  logic [IW-1:0] load_idx,
  input  logic [7:0]    load_byte,
  input  logic          load_care,
  input  logic          step_en,
  input  logic          step_clear,
  input  logic [7:0]    data_byte,
  input  logic [IW-1:0] len_m1,
  output logic          hit
);

  logic [7:0]             pat_r  [MAX_PATTERN];
  logic                   care_r [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] prefix_r;
  logic [MAX_PATTERN-1:0] prefix_nxt;
  logic [MAX_PATTERN-1:0] pos_ok;

  // pattern store, one entry per load item
  always_ff @(posedge clk) begin
    if (load_en) begin
      pat_r[load_idx]  <= load_byte;
      care_r[load_idx] <= load_care;
    end
  end

  // per-position compare of the new byte against every entry
  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      pos_ok[j] = !care_r[j] || (pat_r[j] == data_byte);
    end
  end

  // bit j set: entries 0..j match the bytes ending at the current one
  always_comb begin
    prefix_nxt[0] = pos_ok[0];
    for (int j = 1; j < MAX_PATTERN; j++) begin
      prefix_nxt[j] = pos_ok[j] && prefix_r[j-1];
    end
  end

  assign hit = prefix_nxt[len_m1];

  // prefix vector, cleared at the end of each scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r <= '0;
    end else if (step_en) begin
      prefix_r <= step_clear ? '0 : prefix_nxt;
    end
  end

endmodule

### sv/mbps_outq.sv
`timescale 1ns / 1ps
module mbps_outq import mbps_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         push_n,
  input  result_t            push_d0,
  input  result_t            push_d1,
  input  logic               pop,
  output result_t            head,
  output logic [OUTQ_CW-1:0] count
);

  result_t              mem_r [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0]   wr_ptr_r;
  logic [OUTQ_AW-1:0]   rd_ptr_r;
  logic [OUTQ_CW-1:0]   cnt_r;
  logic [OUTQ_AW-1:0]   wr_ptr1;

  assign wr_ptr1 = wr_ptr_r + OUTQ_AW'(1);

  // up to two writes per cycle
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_ptr_r] <= push_d0;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_ptr1] <= push_d1;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + OUTQ_AW'(push_n);
      rd_ptr_r <= rd_ptr_r + OUTQ_AW'(pop);
      cnt_r    <= cnt_r + OUTQ_CW'(push_n) - OUTQ_CW'(pop);
    end
  end

  assign head  = mem_r[rd_ptr_r];
  assign count = cnt_r;

endmodule

### sv/masked_byte_pattern_scanner.sv
`timescale 1ns / 1ps
// channel   direction  handshake             payload
// in_       input      in_valid / in_ready   mode, entry_index, entry_byte, entry_care,
//                                            data_byte, end_of_region
// out_      output     out_valid / out_ready kind, match_address, match_total, is_last
// cfg_      input      cfg_we                cfg_index, cfg_wdata
//
// one item per cycle while in_ready is high; results pass the first-stage registers, then the result queue
// the masked compare runs over all pattern positions at once with a prefix vector
// a four-entry result queue absorbs the match plus summary pair of a last byte
// in_ready drops while the queue and the pending stage could not take two more results
// rst_n is synchronous; pattern entries hold no reset and need loading first
module masked_byte_pattern_scanner import mbps_pkg::*; #(
  parameter int MAX_PATTERN = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_mode,
  input  logic [6:0]        in_entry_index,
  input  logic [7:0]        in_entry_byte,
  input  logic              in_entry_care,
  input  logic [7:0]        in_data_byte,
  input  logic              in_end_of_region,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_kind,
  output logic [63:0]       out_match_address,
  output logic [6:0]        out_match_total,
  output logic              out_is_last,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [63:0]       cfg_wdata
);

  localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [7:0]         pattern_length_r;
  logic [63:0]        region_base_r;
  logic [6:0]         max_reported_r;

  logic [63:0]        bytes_seen_r;
  logic [63:0]        bytes_seen_nxt;
  logic [6:0]         rc_r;
  logic [6:0]         rc_nxt;

  logic [1:0]         s1_n_r;
  logic               s1_rep_r;
  logic [63:0]        s1_start_r;
  logic [6:0]         s1_total_r;

  logic               accept;
  logic               load_en;
  logic               step_en;
  logic               hit;
  logic               report;
  logic [IW-1:0]      len_m1;
  logic [6:0]         limit;
  logic [OUTQ_CW-1:0] q_count;
  result_t            res0;
  result_t            res1;
  result_t            head;
  logic               pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_length_r <= PATTERN_LENGTH_RST;
      region_base_r    <= '0;
      max_reported_r   <= MAX_REPORTED_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PATTERN_LENGTH: pattern_length_r <= cfg_wdata[7:0];
        CFG_REGION_BASE:    region_base_r    <= cfg_wdata;
        CFG_MAX_REPORTED:   max_reported_r   <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // effective pattern length minus one and report limit
  always_comb begin
    if (pattern_length_r == 8'd0) begin
      len_m1 = '0;
    end else if (int'(pattern_length_r) > MAX_PATTERN) begin
      len_m1 = IW'(MAX_PATTERN - 1);
    end else begin
      len_m1 = IW'(pattern_length_r - 8'd1);
    end
    limit = (max_reported_r > REPORT_CAP) ? REPORT_CAP : max_reported_r;
  end

  // accept while the queue can take a match plus summary after the pending stage
  assign in_ready = (q_count + OUTQ_CW'(s1_n_r)) <= OUTQ_ROOM;
  assign accept   = in_valid && in_ready;
  assign load_en  = accept && (in_mode == MODE_LOAD) && (bytes_seen_r == 64'd0) &&
                    (int'(in_entry_index) < MAX_PATTERN);
  assign step_en  = accept && (in_mode == MODE_REGION);

  mbps_match #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_match (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_en    (load_en),
    .load_idx   (IW'(in_entry_index)),
    .load_byte  (in_entry_byte),
    .load_care  (in_entry_care),
    .step_en    (step_en),
    .step_clear (in_end_of_region),
    .data_byte  (in_data_byte),
    .len_m1     (len_m1),
    .hit        (hit)
  );

  // scan counters
  assign report         = hit && (rc_r < limit);
  assign rc_nxt         = rc_r + 7'(report);
  assign bytes_seen_nxt = bytes_seen_r + 64'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r <= '0;
      rc_r         <= '0;
    end else if (step_en) begin
      bytes_seen_r <= in_end_of_region ? 64'd0 : bytes_seen_nxt;
      rc_r         <= in_end_of_region ? 7'd0 : rc_nxt;
    end
  end

  // first stage: what the item gives
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_n_r <= '0;
    end else begin
      s1_n_r <= step_en ? (2'(report) + 2'(in_end_of_region)) : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      s1_rep_r   <= report;
      s1_start_r <= bytes_seen_r - 64'(len_m1);
      s1_total_r <= rc_nxt;
    end
  end

  // second stage: build result items
  always_comb begin
    res1.kind          = KIND_SUMMARY;
    res1.match_address = '0;
    res1.match_total   = s1_total_r;
    res1.is_last       = 1'b1;
    if (s1_rep_r) begin
      res0.kind          = KIND_MATCH;
      res0.match_address = region_base_r + s1_start_r;
      res0.match_total   = '0;
      res0.is_last       = 1'b0;
    end else begin
      res0 = res1;
    end
  end

  assign pop = out_valid && out_ready;

  mbps_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_n  (s1_n_r),
    .push_d0 (res0),
    .push_d1 (res1),
    .pop     (pop),
    .head    (head),
    .count   (q_count)
  );

  assign out_valid         = q_count != '0;
  assign out_kind          = head.kind;
  assign out_match_address = head.match_address;
  assign out_match_total   = head.match_total;
  assign out_is_last       = head.is_last;

  // checks
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= OUTQ_CW'(OUTQ_DEPTH))
    else $error("result queue overflow");

  a_report_cap: assert property (@(posedge clk) disable iff (!rst_n)
    rc_r <= REPORT_CAP)
    else $error("reported count above cap");

  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_SUMMARY) == out_is_last)
    else $error("summary and last flag disagree");

  a_pair_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_n_r == 2'd2) |-> $past(step_en && in_end_of_region))
    else $error("result pair without a last byte");

endmodule
